FILE: sv/ipbl_pkg.sv
package ipbl_pkg;

    localparam int TABLE_DEPTH   = 128;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_COUNT_W = 8;
    localparam int GROUP_SIZE    = 8;
    localparam int NUM_GROUPS    = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;

    localparam logic [15:0] FAMILY_IPV4  = 16'd2;
    localparam logic [9:0]  MIN_ADDR_LEN = 10'd8;
    localparam logic [9:0]  MAX_ADDR_LEN = 10'd512;

    typedef struct packed {
        logic [31:0] ip_addr;
        logic [15:0] port;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic lookup;
    } cell_ctrl_t;

endpackage

FILE: sv/ipbl_if.sv
interface ipbl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] ip_addr;
    logic [15:0] port;
    logic [15:0] addr_family;
    logic [9:0]  addr_len;

    modport source (output valid, output action, output ip_addr, output port,
                    output addr_family, output addr_len, input ready);
    modport sink   (input valid, input action, input ip_addr, input port,
                    input addr_family, input addr_len, output ready);
endinterface

interface ipbl_out_if;
    logic       valid;
    logic       ready;
    logic       blocked;
    logic       added;
    logic [7:0] entry_count;

    modport source (output valid, output blocked, output added, output entry_count,
                    input ready);
    modport sink   (input valid, input blocked, input added, input entry_count,
                    output ready);
endinterface

FILE: sv/ipv4_port_blocklist_matcher.sv
// Channel | Dir | Fields                                          | Handshake
// req     | in  | action, ip_addr, port, addr_family, addr_len    | valid/ready
// rsp     | out | blocked, added, entry_count                     | valid/ready
//
// Each item holds the block through cell compare at the transfer edge, group OR,
// final OR and result register; rsp.valid rises when the result register loads.
// Adds shift the new entry into the cell row head at the transfer edge, if not full.
// Reset clears all cell valid bits and the entry count; entries need no clearing.
// A waiting result does not block the next transfer; that item then holds in S_OUT
// and req.ready stays low until the waiting result transfers.
module ipv4_port_blocklist_matcher
    import ipbl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ipbl_in_if.sink       req,
    ipbl_out_if.source    rsp
);

    typedef enum logic [1:0] {S_IDLE, S_GRP, S_FIN, S_OUT} state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   add_reg, add_next;
    logic                   chk_reg, chk_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_blocked_reg, out_blocked_next;
    logic                   out_added_reg, out_added_next;
    logic [ENTRY_COUNT_W-1:0] out_count_reg, out_count_next;

    logic                   accept;
    logic                   full;
    logic                   qual;
    cell_ctrl_t             ctrl;
    entry_t                 query;
    entry_t                 cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] cell_hit;
    logic                   any_hit;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = cell_valid[TABLE_DEPTH-1];
    assign qual      = (req.addr_family == FAMILY_IPV4) &&
                       (req.addr_len >= MIN_ADDR_LEN) && (req.addr_len <= MAX_ADDR_LEN);

    assign query.ip_addr = req.ip_addr;
    assign query.port    = req.port;

    assign ctrl.shift  = accept && (req.action == ACT_ADD) && !full;
    assign ctrl.clear  = accept && (req.action == ACT_CLEAR);
    assign ctrl.lookup = accept && (req.action == ACT_CHECK) && qual;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   prev_valid;
        if (i == 0)
        begin : g_head
            assign prev_entry = query;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_entry = cell_entry[i-1];
            assign prev_valid = cell_valid[i-1];
        end
        ipbl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .query      (query),
            .prev_entry (prev_entry),
            .prev_valid (prev_valid),
            .entry      (cell_entry[i]),
            .valid      (cell_valid[i]),
            .hit        (cell_hit[i])
        );
    end

    ipbl_hit_tree u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .hits    (cell_hit),
        .any_hit (any_hit)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        add_next         = add_reg;
        chk_next         = chk_reg;
        out_valid_next   = out_valid_reg;
        out_blocked_next = out_blocked_reg;
        out_added_next   = out_added_reg;
        out_count_next   = out_count_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    add_next = ctrl.shift;
                    chk_next = ctrl.lookup;
                    if (ctrl.clear)
                    begin
                        count_next = '0;
                    end
                    else if (ctrl.shift)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_GRP;
                end
            end
            S_GRP:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_blocked_next = chk_reg && any_hit;
                    out_added_next   = add_reg;
                    out_count_next   = ENTRY_COUNT_W'(count_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            add_reg         <= 1'b0;
            chk_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_blocked_reg <= 1'b0;
            out_added_reg   <= 1'b0;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            add_reg         <= add_next;
            chk_reg         <= chk_next;
            out_valid_reg   <= out_valid_next;
            out_blocked_reg <= out_blocked_next;
            out_added_reg   <= out_added_next;
            out_count_reg   <= out_count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.blocked     = out_blocked_reg;
    assign rsp.added       = out_added_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        full == (count_reg == CNT_W'(TABLE_DEPTH)))
        else $error("last cell valid bit disagrees with entry count");

    a_add_increments: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not advance entry count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (count_reg == '0) && (cell_valid[0] == 1'b0))
        else $error("clear left entries valid");

endmodule

FILE: sv/ipbl_cell.sv
module ipbl_cell
    import ipbl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     query,
    input  entry_t     prev_entry,
    input  logic       prev_valid,
    output entry_t     entry,
    output logic       valid,
    output logic       hit
);

    entry_t entry_reg;
    logic   valid_reg;
    logic   hit_reg;
    logic   match;

    assign match = (entry_reg.ip_addr == query.ip_addr) &&
                   ((entry_reg.port == 16'd0) || (entry_reg.port == query.port));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (ctrl.shift)
            begin
                valid_reg <= prev_valid;
            end
            if (ctrl.lookup)
            begin
                hit_reg <= valid_reg && match;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= prev_entry;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

FILE: sv/ipbl_hit_tree.sv
module ipbl_hit_tree
    import ipbl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [TABLE_DEPTH-1:0] hits,
    output logic                   any_hit
);

    logic [NUM_GROUPS*GROUP_SIZE-1:0] padded;
    logic [NUM_GROUPS-1:0]            group_reg;
    logic [NUM_GROUPS-1:0]            group_next;
    logic                             any_reg;

    assign padded = (NUM_GROUPS*GROUP_SIZE)'(hits);

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            group_reg <= group_next;
            any_reg   <= |group_reg;
        end
    end

    assign any_hit = any_reg;

endmodule
